FILE: hdl/gpl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GPIO pin list parser package
// Shared types, character codes and helpers for the pin list parser.
// ----------------------------------------------------------------------------
package gpl_pkg;

    localparam int PIN_SLOTS_DEF = 128;
    localparam int PORT_W        = 3;
    localparam int PIN_W         = 7;
    localparam int CODE_W        = 7;
    localparam int MODE_W        = 3;
    localparam int CHAR_W        = 8;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_P     = 8'h50;
    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_H     = 8'h48;
    localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CHAR_SEMI  = 8'h3B;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;

    localparam logic [PIN_W-1:0] PIN_MAX  = 7'd15;
    localparam logic [PIN_W-1:0] DEC_BASE = 7'd10;

    typedef logic [PORT_W-1:0] t_port;
    typedef logic [PIN_W-1:0]  t_pin;
    typedef logic [CODE_W-1:0] t_code;
    typedef logic [MODE_W-1:0] t_mode;
    typedef logic [CHAR_W-1:0] t_char;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_PORT,
        PH_DIG1,
        PH_DIG2
    } t_phase;

    typedef struct packed {
        logic  start_set;
        t_char char_byte;
        t_mode list_mode;
    } t_item;

    typedef struct packed {
        logic  pin_ready;
        t_code pin_code;
        t_mode pin_mode;
        logic  failed;
        logic  list_end;
    } t_result;

    function automatic logic is_gap(input t_char c);
        is_gap = (c == CHAR_COMMA) || (c == CHAR_SEMI) || (c == CHAR_SPACE) ||
                 (c == CHAR_TAB) || (c == CHAR_CR) || (c == CHAR_LF);
    endfunction

endpackage
`default_nettype wire

FILE: hdl/gpl_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GPIO pin list parser core
// Token phase, port and pin registers, used pin map and sticky error; one
// character handled per fire.
// ----------------------------------------------------------------------------
module gpl_parser #(
    parameter int PIN_SLOTS = gpl_pkg::PIN_SLOTS_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_fire,
    input  gpl_pkg::t_item   i_item,
    output gpl_pkg::t_result o_result
);

    localparam int IDX_W = $clog2(PIN_SLOTS);

    gpl_pkg::t_phase     r_phase, n_phase, cur_phase;
    gpl_pkg::t_port      r_port, n_port, cur_port;
    gpl_pkg::t_pin       r_pin, n_pin, cur_pin;
    logic                r_err, n_err, cur_err;
    logic [PIN_SLOTS-1:0] r_map, n_map, cur_map;

    gpl_pkg::t_char      c;
    gpl_pkg::t_pin       dig;
    gpl_pkg::t_code      code;
    logic [IDX_W-1:0]    idx;
    logic                ends;
    logic                in_range;
    logic                is_dig;
    logic                bad;
    logic                ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= gpl_pkg::PH_IDLE;
            r_port  <= '0;
            r_pin   <= '0;
            r_err   <= 1'b0;
            r_map   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_port  <= n_port;
            r_pin   <= n_pin;
            r_err   <= n_err;
            r_map   <= n_map;
        end
    end

    always_comb begin
        c         = i_item.char_byte;
        ends      = (c == gpl_pkg::CHAR_NUL);
        is_dig    = (c inside {[gpl_pkg::CHAR_0:gpl_pkg::CHAR_9]});
        dig       = gpl_pkg::t_pin'(c - gpl_pkg::CHAR_0);

        cur_phase = i_item.start_set ? gpl_pkg::PH_IDLE : r_phase;
        cur_port  = i_item.start_set ? '0 : r_port;
        cur_pin   = i_item.start_set ? '0 : r_pin;
        cur_err   = i_item.start_set ? 1'b0 : r_err;
        cur_map   = i_item.start_set ? '0 : r_map;

        code      = {cur_port, cur_pin[3:0]};
        idx       = code[IDX_W-1:0];
        in_range  = (32'(code) < PIN_SLOTS);

        n_phase   = cur_phase;
        n_port    = cur_port;
        n_pin     = cur_pin;
        n_err     = cur_err;
        n_map     = cur_map;
        bad       = 1'b0;
        ready     = 1'b0;

        if (!cur_err) begin
            if (ends || gpl_pkg::is_gap(c)) begin
                case (cur_phase)
                    gpl_pkg::PH_LEAD, gpl_pkg::PH_PORT: begin
                        bad = 1'b1;
                    end
                    gpl_pkg::PH_DIG1, gpl_pkg::PH_DIG2: begin
                        if ((cur_pin <= gpl_pkg::PIN_MAX) && in_range && !cur_map[idx]) begin
                            ready      = 1'b1;
                            n_map[idx] = 1'b1;
                        end else begin
                            bad = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                n_phase = gpl_pkg::PH_IDLE;
            end else begin
                case (cur_phase)
                    gpl_pkg::PH_IDLE: begin
                        if (c == gpl_pkg::CHAR_P) begin
                            n_phase = gpl_pkg::PH_LEAD;
                        end else begin
                            bad = 1'b1;
                        end
                    end
                    gpl_pkg::PH_LEAD: begin
                        if (c inside {[gpl_pkg::CHAR_A:gpl_pkg::CHAR_H]}) begin
                            n_port  = gpl_pkg::t_port'(c - gpl_pkg::CHAR_A);
                            n_phase = gpl_pkg::PH_PORT;
                        end else begin
                            bad = 1'b1;
                        end
                    end
                    gpl_pkg::PH_PORT: begin
                        if (is_dig) begin
                            n_pin   = dig;
                            n_phase = gpl_pkg::PH_DIG1;
                        end else begin
                            bad = 1'b1;
                        end
                    end
                    gpl_pkg::PH_DIG1: begin
                        if (is_dig) begin
                            n_pin   = gpl_pkg::t_pin'(cur_pin * gpl_pkg::DEC_BASE + dig);
                            n_phase = gpl_pkg::PH_DIG2;
                        end else begin
                            bad = 1'b1;
                        end
                    end
                    default: begin
                        bad = 1'b1;
                    end
                endcase
            end
            if (bad) begin
                n_err   = 1'b1;
                ready   = 1'b0;
                n_map   = cur_map;
                n_phase = gpl_pkg::PH_IDLE;
            end
        end

        o_result.pin_ready = ready;
        o_result.pin_code  = ready ? code : '0;
        o_result.pin_mode  = ready ? i_item.list_mode : '0;
        o_result.failed    = n_err;
        o_result.list_end  = ends;
    end

endmodule
`default_nettype wire

FILE: hdl/gpio_pin_list_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GPIO pin list parser
// Takes one character a cycle unless back-pressure holds the output register,
// each tagged with its pin-mode list, and returns one result per character: a
// completed pin code (port*16+pin) with its mode, the sticky failure flag and
// an end-of-list mark. Each result passes through the input register, then
// the parser stage and output register; the parser updates the token phase
// and the used pin map as the result is registered. A start_set character
// clears the map and the failure flag before it is parsed.
// ----------------------------------------------------------------------------
module gpio_pin_list_parser #(
    parameter int PIN_SLOTS = gpl_pkg::PIN_SLOTS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  wire [15:0] i_s_axis_tdata,   // [7:0] char_byte, [10:8] list_mode
    input  wire        i_s_axis_tuser,   // [0] start_set
    output logic       o_m_axis_tvalid,
    input  wire        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,  // [6:0] pin_code, [9:7] pin_mode, [10] failed
    output logic       o_m_axis_tuser,   // [0] pin_ready
    output logic       o_m_axis_tlast    // list_end
);

    logic             r_in_valid;
    gpl_pkg::t_item   r_in;
    logic             r_out_valid;
    gpl_pkg::t_result r_out;

    gpl_pkg::t_item   in_item;
    gpl_pkg::t_result result;
    logic             out_adv;
    logic             fire;

    assign out_adv         = !r_out_valid || i_m_axis_tready;
    assign fire            = r_in_valid && out_adv;
    assign o_s_axis_tready = !r_in_valid || out_adv;

    assign in_item.start_set = i_s_axis_tuser;
    assign in_item.char_byte = i_s_axis_tdata[7:0];
    assign in_item.list_mode = i_s_axis_tdata[10:8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (out_adv) begin
                r_out_valid <= fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready) begin
            r_in <= in_item;
        end
        if (out_adv) begin
            r_out <= result;
        end
    end

    gpl_parser #(
        .PIN_SLOTS (PIN_SLOTS)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .o_result (result)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b0, r_out.failed, r_out.pin_mode, r_out.pin_code};
    assign o_m_axis_tuser  = r_out.pin_ready;
    assign o_m_axis_tlast  = r_out.list_end;

endmodule
`default_nettype wire
